// File: design/cia_pkg.sv
// Shared constants and types for the complex integer ALU.
// No dependencies; imported by cia_div, complex_integer_alu_unit and its testbench.
`default_nettype none
package cia_pkg;
   localparam int OPERAND_WIDTH = 16;
   localparam int MAG_W = 2 * OPERAND_WIDTH;     // product-sum magnitude, quotient
   localparam int SUM_W = 2 * OPERAND_WIDTH + 2; // signed sums, exact
   localparam int RES_W = 33;                    // result field width
   localparam int OP_W = 2;
   localparam int REQ_DATA_W = ((4 * OPERAND_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * RES_W + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL = 2'd2;
   localparam logic [OP_W-1:0] OP_DIV = 2'd3;

   // sideband that rides along the divider pipeline
   typedef struct packed {
      logic neg_re;
      logic neg_im;
      logic dbz;
   } side_type;
endpackage
`default_nettype wire

// File: design/cia_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes
// sharing one divisor, plus a sign-applying output register. Uses cia_pkg.
`default_nettype none
module cia_div (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  wire [cia_pkg::MAG_W-1:0]         in_num_re,
   input  wire [cia_pkg::MAG_W-1:0]         in_num_im,
   input  wire [cia_pkg::MAG_W-1:0]         in_den,
   input  wire cia_pkg::side_type           in_side,
   output logic                             out_valid,
   input  wire                              out_ready,
   output logic signed [cia_pkg::RES_W-1:0] out_re,
   output logic signed [cia_pkg::RES_W-1:0] out_im,
   output logic                             out_dbz
);
   import cia_pkg::*;

   localparam int M = MAG_W;
   localparam int ACC_W = 2 * M;

   // acc: upper half partial remainder, lower half numerator shifting into quotient
   function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                 input logic [M-1:0] den);
      logic [M:0] trial;
      logic [M:0] diff;
      trial = {acc[ACC_W-1:M], acc[M-1]};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         div_step = {diff[M-1:0], acc[M-2:0], 1'b1};
      end else begin
         div_step = {acc[ACC_W-2:0], 1'b0};
      end
   endfunction

   logic [ACC_W-1:0] acc_re_ff [M];
   logic [ACC_W-1:0] acc_im_ff [M];
   logic [M-1:0]     den_ff    [M];
   side_type         side_ff   [M];
   logic [M-1:0]     vld_ff;
   logic [M:0]       en;

   logic                    out_vld_ff;
   logic signed [RES_W-1:0] re_ff, im_ff;
   logic                    dbz_ff;
   logic signed [M:0]       sq_re, sq_im;

   assign en[M] = out_ready || !out_vld_ff;
   for (genvar j = 0; j < M; j++) begin : g_en
      assign en[j] = !vld_ff[j] || en[j+1];
   end
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int j = 1; j < M; j++) begin
            if (en[j]) begin
               vld_ff[j] <= vld_ff[j-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         acc_re_ff[0] <= div_step({{M{1'b0}}, in_num_re}, in_den);
         acc_im_ff[0] <= div_step({{M{1'b0}}, in_num_im}, in_den);
         den_ff[0]    <= in_den;
         side_ff[0]   <= in_side;
      end
      for (int j = 1; j < M; j++) begin
         if (en[j]) begin
            acc_re_ff[j] <= div_step(acc_re_ff[j-1], den_ff[j-1]);
            acc_im_ff[j] <= div_step(acc_im_ff[j-1], den_ff[j-1]);
            den_ff[j]    <= den_ff[j-1];
            side_ff[j]   <= side_ff[j-1];
         end
      end
   end

   // quotient sits in the low half after the last step
   assign sq_re = {1'b0, acc_re_ff[M-1][M-1:0]};
   assign sq_im = {1'b0, acc_im_ff[M-1][M-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en[M]) begin
         out_vld_ff <= vld_ff[M-1];
      end
      if (en[M]) begin
         re_ff  <= RES_W'(side_ff[M-1].neg_re ? -sq_re : sq_re);
         im_ff  <= RES_W'(side_ff[M-1].neg_im ? -sq_im : sq_im);
         dbz_ff <= side_ff[M-1].dbz;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_re    = re_ff;
   assign out_im    = im_ff;
   assign out_dbz   = dbz_ff;
endmodule
`default_nettype wire

// File: design/complex_integer_alu_unit.sv
// Complex integer ALU top level: multiply, sum and sign stages feeding
// the pipelined divider. Uses cia_pkg and cia_div.
`default_nettype none
// Add, subtract, multiply or divide two complex integers with 16-bit signed
// parts; results are exact 33-bit signed values, division truncates each part
// toward zero, and a divide by 0+0i returns zeros with rsp_tuser set. One
// request is accepted per cycle while the pipe is not stalled by rsp_tready;
// every request passes the same 3 + 32 + 1 = 36 register stages. The depth
// is set by the 32-stage bit-per-stage divider that all operations pass
// through (non-divide operations divide by one). Each stage stalls on its
// own, so bubbles are squeezed out and input is still taken while a
// finished result waits on rsp_tready.
module complex_integer_alu_unit (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // a_real, a_imag, b_real, b_imag (low to high)
   input  wire [cia_pkg::REQ_DATA_W-1:0]     req_tdata,
   // op
   input  wire [cia_pkg::OP_W-1:0]           req_tuser,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // res_real, res_imag, zero pad (low to high)
   output logic [cia_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // divide_by_zero
   output logic                              rsp_tuser
);
   import cia_pkg::*;

   localparam int W = OPERAND_WIDTH;

   logic signed [W-1:0] ar, ai, br, bi;
   assign ar = req_tdata[W-1:0];
   assign ai = req_tdata[2*W-1:W];
   assign br = req_tdata[3*W-1:2*W];
   assign bi = req_tdata[4*W-1:3*W];

   // stage enables, back to front
   logic div_ready, en1, en2, en3;
   logic v1_ff, v2_ff, v3_ff;
   assign en3 = !v3_ff || div_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   // stage 1: six products, operands kept for add/sub
   logic [OP_W-1:0]       op1_ff;
   logic signed [W-1:0]   ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [2*W-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff, p_dr_ff, p_di_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_tvalid;
      end
      if (en1) begin
         op1_ff  <= req_tuser;
         ar1_ff  <= ar;
         ai1_ff  <= ai;
         br1_ff  <= br;
         bi1_ff  <= bi;
         p_rr_ff <= ar * br;
         p_ii_ff <= ai * bi;
         p_ir_ff <= ai * br;
         p_ri_ff <= ar * bi;
         p_dr_ff <= br * br;
         p_di_ff <= bi * bi;
      end
   end

   // stage 2: exact signed sums per operation
   logic signed [SUM_W-1:0] re_s, im_s;
   logic [MAG_W-1:0]        den_s;

   always_comb begin
      case (op1_ff)
         OP_ADD: begin
            re_s = SUM_W'(ar1_ff) + SUM_W'(br1_ff);
            im_s = SUM_W'(ai1_ff) + SUM_W'(bi1_ff);
         end
         OP_SUB: begin
            re_s = SUM_W'(ar1_ff) - SUM_W'(br1_ff);
            im_s = SUM_W'(ai1_ff) - SUM_W'(bi1_ff);
         end
         OP_MUL: begin
            re_s = SUM_W'(p_rr_ff) - SUM_W'(p_ii_ff);
            im_s = SUM_W'(p_ir_ff) + SUM_W'(p_ri_ff);
         end
         default: begin // divide: numerators of a * conj(b)
            re_s = SUM_W'(p_rr_ff) + SUM_W'(p_ii_ff);
            im_s = SUM_W'(p_ir_ff) - SUM_W'(p_ri_ff);
         end
      endcase
      // squares are non-negative and each below 2^(2W-1)+1
      den_s = MAG_W'(p_dr_ff) + MAG_W'(p_di_ff);
   end

   logic signed [SUM_W-1:0] re2_ff, im2_ff;
   logic [MAG_W-1:0]        den2_ff;
   logic                    div2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         re2_ff  <= re_s;
         im2_ff  <= im_s;
         den2_ff <= den_s;
         div2_ff <= (op1_ff == OP_DIV);
      end
   end

   // stage 3: sign/magnitude; non-divide ops divide by one,
   // a zero divisor becomes 0 / 1 with the flag set
   logic                    dbz3;
   logic signed [SUM_W-1:0] abs_re, abs_im;
   assign dbz3   = div2_ff && (den2_ff == '0);
   assign abs_re = re2_ff[SUM_W-1] ? -re2_ff : re2_ff;
   assign abs_im = im2_ff[SUM_W-1] ? -im2_ff : im2_ff;

   logic [MAG_W-1:0] num_re3_ff, num_im3_ff, den3_ff;
   side_type         side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3) begin
         num_re3_ff      <= dbz3 ? '0 : abs_re[MAG_W-1:0];
         num_im3_ff      <= dbz3 ? '0 : abs_im[MAG_W-1:0];
         den3_ff         <= div2_ff && !dbz3 ? den2_ff : MAG_W'(1);
         side3_ff.neg_re <= re2_ff[SUM_W-1] && !dbz3;
         side3_ff.neg_im <= im2_ff[SUM_W-1] && !dbz3;
         side3_ff.dbz    <= dbz3;
      end
   end

   logic signed [RES_W-1:0] res_re, res_im;

   cia_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_ready  (div_ready),
      .in_num_re (num_re3_ff),
      .in_num_im (num_im3_ff),
      .in_den    (den3_ff),
      .in_side   (side3_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_re    (res_re),
      .out_im    (res_im),
      .out_dbz   (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'({res_im, res_re});

`ifndef NO_ASSERTIONS
   // a flagged divide always carries zero parts
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (res_re == '0) && (res_im == '0))
      else $error("divide-by-zero result not zero");

   // a stalled front stage keeps its request
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !en2 |=> v1_ff)
      else $error("stage 1 request lost during stall");

   // a zero-divisor flag comes with its divisor replaced by one
   a_dbz_div: assert property (@(posedge clock) disable iff (reset)
      v3_ff && side3_ff.dbz |-> den3_ff == MAG_W'(1))
      else $error("zero divisor not replaced");
`endif
endmodule
`default_nettype wire

// File: verif/complex_integer_alu_unit_tb.sv
// Self-checking testbench for complex_integer_alu_unit: drives random and
// directed complex-integer requests and checks every response. Uses cia_pkg.
`default_nettype none
module complex_integer_alu_unit_tb;
   import cia_pkg::*;

   localparam int LATENCY = 36;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // a_real, a_imag, b_real, b_imag
   logic [OP_W-1:0] req_tuser = '0;         // op
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // res_real, res_imag, pad
   logic rsp_tuser;                         // divide_by_zero

   typedef struct packed {
      logic [RES_W-1:0] re;
      logic [RES_W-1:0] im;
      logic dbz;
   } result_type;

   result_type expected_results[$];
   int mismatch_count = 0;
   int response_count = 0;
   int request_count = 0;
   longint cycle_count = 0;
   int send_idle_pct = 17;      // sender gap chance, percent
   int recv_idle_pct = 17;      // receiver stall chance, percent
   int hold_off_cycles = 0;     // forced receiver stall, counted below

   complex_integer_alu_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact complex arithmetic; divide truncates toward zero ('/' on
   // signed longint already does), zero divisor flags and returns zeros.
   function automatic result_type complex_result(logic [OP_W-1:0] op,
         logic signed [15:0] ar, logic signed [15:0] ai,
         logic signed [15:0] br, logic signed [15:0] bi);
      result_type r;
      longint re_v;
      longint im_v;
      longint den;
      r.dbz = 1'b0;
      re_v = 0;
      im_v = 0;
      case (op)
         OP_ADD: begin
            re_v = longint'(ar) + longint'(br);
            im_v = longint'(ai) + longint'(bi);
         end
         OP_SUB: begin
            re_v = longint'(ar) - longint'(br);
            im_v = longint'(ai) - longint'(bi);
         end
         OP_MUL: begin
            re_v = longint'(ar) * br - longint'(ai) * bi;
            im_v = longint'(ai) * br + longint'(ar) * bi;
         end
         default: begin
            den = longint'(br) * br + longint'(bi) * bi;
            if (den == 0) begin
               r.dbz = 1'b1;
            end else begin
               re_v = (longint'(ar) * br + longint'(ai) * bi) / den;
               im_v = (longint'(ai) * br - longint'(ar) * bi) / den;
            end
         end
      endcase
      r.re = re_v[RES_W-1:0];
      r.im = im_v[RES_W-1:0];
      return r;
   endfunction

   // Offer one request and hold it until accepted; gaps drawn beforehand.
   // tvalid stays high after acceptance until the next gap or drain.
   task automatic send_request(logic [OP_W-1:0] op, logic [15:0] ar, logic [15:0] ai,
         logic [15:0] br, logic [15:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {bi, br, ai, ar};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(complex_result(op, ar, ai, br, bi));
      request_count++;
   endtask

   task automatic send_random(int n, bit signs_only);
      logic [15:0] v[4];
      for (int i = 0; i < n; i++) begin
         foreach (v[k]) begin
            case ($urandom_range(5))
               0: v[k] = 16'h8000;
               1: v[k] = 16'h7fff;
               2: v[k] = 16'($urandom_range(0, 6)) - 16'd3;
               default: v[k] = 16'($urandom);
            endcase
         end
         if ($urandom_range(15) == 0) begin
            v[2] = '0;
            v[3] = '0;
         end
         if (signs_only) v[0] = {v[0][15], 15'($urandom)};
         send_request(2'($urandom), v[0], v[1], v[2], v[3]);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Extremes, every op and the zero-divisor case.
   task automatic test_directed();
      logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      for (int op = 0; op < 4; op++) begin
         send_request(2'(op), ext[0], ext[0], ext[0], ext[0]);
         send_request(2'(op), ext[1], ext[1], ext[0], ext[0]);
         send_request(2'(op), ext[0], ext[1], ext[1], ext[0]);
         send_request(2'(op), ext[1], ext[0], ext[3], ext[2]);
      end
      send_request(OP_DIV, 16'd7, 16'hfff9, 16'd0, 16'd0);          // zero divisor
      send_request(OP_DIV, 16'h7fff, 16'h8000, 16'd0, 16'd0);
      send_request(OP_DIV, 16'hfff9, 16'd7, 16'd2, 16'd0);          // truncation
      send_request(OP_DIV, 16'd5, 16'hfffb, 16'd1, 16'd1);
      send_request(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
   endtask

   // Receiver stops for a long stretch while requests keep coming.
   task automatic test_backpressure();
      hold_off_cycles = 200;
      send_random(120, 1'b0);
      wait_drained();
   endtask

   // Sender pauses with the pipe empty, then resumes.
   task automatic test_pause_and_resume();
      wait_drained();
      repeat (LATENCY) @(posedge clock);
      send_random(30, 1'b1);
   endtask

   task automatic test_random_traffic();
      send_random(500, 1'b0);
      send_idle_pct = 0;        // stretch with no idling on either side
      recv_idle_pct = 0;
      send_random(300, 1'b0);
      send_idle_pct = 17;
      recv_idle_pct = 17;
      send_random(480, 1'b0);
   endtask

   // Receiver ready: random stalls, or a counted hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response checker against the oldest outstanding expectation.
   always @(posedge clock) begin
      result_type want;
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         response_count++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[RES_W-1:0] !== want.re ||
                  rsp_tdata[2*RES_W-1:RES_W] !== want.im || rsp_tuser !== want.dbz) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: want re %h im %h dbz %b, got re %h im %h dbz %b",
                     want.re, want.im, want.dbz, rsp_tdata[RES_W-1:0],
                     rsp_tdata[2*RES_W-1:RES_W], rsp_tuser);
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_pause_and_resume();
      test_random_traffic();
      wait_drained();
      repeat (LATENCY + 4) @(posedge clock);
      $display("%0d requests sent, %0d responses checked, all ops, extremes,",
         request_count, response_count);
      $display("zero divisors, long output stall and idle pauses exercised");
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("complex_integer_alu_unit verification clean");
      end else begin
         $display("complex_integer_alu_unit verification failed");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("complex_integer_alu_unit verification failed");
      $finish;
   end
endmodule
`default_nettype wire
